// File: rtl/core/glcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcp_pkg
// Shared constants and types of the GIF LZW code packer.
// ----------------------------------------------------------------------------
package glcp_pkg;

  localparam int unsigned HASH_SLOTS     = 5003;
  localparam int unsigned SLOT_AW        = $clog2(HASH_SLOTS);
  localparam int unsigned MAX_CODE_BITS  = 12;
  localparam int unsigned SUBBLOCK_BYTES = 254;
  localparam int unsigned HASH_SHIFT     = 4;
  localparam int unsigned KEY_W          = 8 + MAX_CODE_BITS;
  localparam int unsigned ENTRY_W        = 1 + KEY_W + MAX_CODE_BITS;

  // command from the dictionary controller to the bit packer
  typedef struct packed {
    logic                     put;
    logic                     fin;
    logic                     img_end;
    logic [MAX_CODE_BITS-1:0] code;
    logic [3:0]               width;
  } pk_cmd_t;

endpackage

// File: rtl/core/gif_lzw_code_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gif_lzw_code_packer
// GIF variable-width LZW encoder with a double-hashed dictionary in RAM.
// ----------------------------------------------------------------------------
// One pixel transaction at a time. A pixel that hits the dictionary takes
// one more RAM read per extra probe; a miss also sends each emitted code
// to the packer, and output bytes drain at one per cycle through the packer
// while out_stall_i is low. The first pixel of each image and every
// dictionary reset (4096 codes used) are followed by a clearing sweep of
// the 5003-entry table, during which no pixel is accepted. min_code_size
// is sampled at the first pixel of each image.
module gif_lzw_code_packer
  import glcp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] min_code_size_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] pixel_index_i,
  input  logic       last_pixel_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       subblock_end_o,
  output logic [7:0] subblock_length_o,
  output logic       image_done_o,
  output logic       run_last_o
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_CHECK      = 4'd1;
  localparam logic [3:0] S_PUT_PREFIX = 4'd2;
  localparam logic [3:0] S_PUT_CLEAR  = 4'd3;
  localparam logic [3:0] S_PUT_LAST   = 4'd4;
  localparam logic [3:0] S_PUT_EOF    = 4'd5;
  localparam logic [3:0] S_FIN        = 4'd6;
  localparam logic [3:0] S_SWEEP      = 4'd7;

  localparam logic [SLOT_AW-1:0] SLOTS = SLOT_AW'(HASH_SLOTS);
  localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(HASH_SLOTS - 1);
  localparam int unsigned CW = MAX_CODE_BITS;

  logic [3:0]         state_q, state_d;
  logic [3:0]         min_q;
  logic [3:0]         img_q, img_d;
  logic [CW-1:0]      prefix_q, prefix_d;
  logic [CW:0]        nfree_q, nfree_d;
  logic [3:0]         width_q, width_d;
  logic               rpend_q, rpend_d;
  logic               first_q, first_d;
  logic               last_q, last_d;
  logic               sweep_q, sweep_d;
  logic [SLOT_AW-1:0] scnt_q, scnt_d;
  logic [7:0]         c_q, c_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [SLOT_AW-1:0] idx_q, idx_d;
  logic [SLOT_AW-1:0] disp_q, disp_d;

  pk_cmd_t            cmd;
  logic               pk_ready;

  logic               ram_we, ram_re;
  logic [SLOT_AW-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [3:0]         size_new;
  logic [7:0]         pix_m;
  logic [SLOT_AW-1:0] idx_raw, idx_new, idx_step;
  logic [CW:0]        limit;
  logic [3:0]         width_nx;
  logic [CW-1:0]      clear_code;
  logic               hit;

  always_comb begin
    if (min_q < 4'd2) begin
      size_new = 4'd2;
    end else if (min_q > 4'd8) begin
      size_new = 4'd8;
    end else begin
      size_new = min_q;
    end
  end

  assign pix_m = pixel_index_i
               & 8'((9'd1 << (first_q ? size_new : img_q)) - 9'd1);
  assign idx_raw = SLOT_AW'({pix_m, {HASH_SHIFT{1'b0}}} ^ prefix_q);
  assign idx_new = (idx_raw >= SLOTS) ? idx_raw - SLOTS : idx_raw;
  assign idx_step = (idx_q >= disp_q) ? idx_q - disp_q : idx_q + SLOTS - disp_q;
  assign limit = (width_q >= 4'(CW)) ? (CW+1)'(1 << CW)
                                      : ((CW+1)'(1) << width_q) - (CW+1)'(1);
  assign clear_code = CW'((CW+1)'(1) << img_q);
  assign hit = ram_rdata[ENTRY_W-1] && (ram_rdata[ENTRY_W-2:CW] == key_q);

  always_comb begin
    if (rpend_q) begin
      width_nx = img_q + 4'd1;
    end else if (nfree_q > limit && width_q < 4'(CW)) begin
      width_nx = width_q + 4'd1;
    end else begin
      width_nx = width_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    img_d     = img_q;
    prefix_d  = prefix_q;
    nfree_d   = nfree_q;
    width_d   = width_q;
    rpend_d   = rpend_q;
    first_d   = first_q;
    last_d    = last_q;
    sweep_d   = sweep_q;
    scnt_d    = scnt_q;
    c_d       = c_q;
    key_d     = key_q;
    idx_d     = idx_q;
    disp_d    = disp_q;
    cmd       = '0;
    cmd.width = width_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = {1'b1, key_q, nfree_q[CW-1:0]};
    ram_raddr = idx_new;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d = last_pixel_i;
          if (first_q) begin
            img_d    = size_new;
            nfree_d  = ((CW+1)'(1) << size_new) + (CW+1)'(2);
            width_d  = size_new + 4'd1;
            rpend_d  = 1'b0;
            prefix_d = CW'(pix_m);
            sweep_d  = 1'b1;
            first_d  = 1'b0;
            state_d  = S_PUT_CLEAR;
          end else begin
            c_d     = pix_m;
            key_d   = {pix_m, prefix_q};
            idx_d   = idx_new;
            disp_d  = (idx_new == '0) ? SLOT_AW'(1) : SLOTS - idx_new;
            ram_re  = 1'b1;
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (hit) begin
          prefix_d = ram_rdata[CW-1:0];
          state_d  = last_q ? S_PUT_LAST : S_FIN;
        end else if (!ram_rdata[ENTRY_W-1]) begin
          state_d = S_PUT_PREFIX;
        end else begin
          idx_d     = idx_step;
          ram_re    = 1'b1;
          ram_raddr = idx_step;
        end
      end
      S_PUT_PREFIX: begin
        if (pk_ready) begin
          cmd.put  = 1'b1;
          cmd.code = prefix_q;
          width_d  = width_nx;
          rpend_d  = 1'b0;
          prefix_d = CW'(c_q);
          if (!nfree_q[CW]) begin
            ram_we  = 1'b1;
            nfree_d = nfree_q + (CW+1)'(1);
            state_d = last_q ? S_PUT_LAST : S_FIN;
          end else begin
            nfree_d = (CW+1)'(clear_code) + (CW+1)'(2);
            rpend_d = 1'b1;
            sweep_d = 1'b1;
            state_d = S_PUT_CLEAR;
          end
        end
      end
      S_PUT_CLEAR: begin
        if (pk_ready) begin
          cmd.put  = 1'b1;
          cmd.code = clear_code;
          width_d  = width_nx;
          rpend_d  = 1'b0;
          state_d  = last_q ? S_PUT_LAST : S_FIN;
        end
      end
      S_PUT_LAST: begin
        if (pk_ready) begin
          cmd.put  = 1'b1;
          cmd.code = prefix_q;
          width_d  = width_nx;
          rpend_d  = 1'b0;
          state_d  = S_PUT_EOF;
        end
      end
      S_PUT_EOF: begin
        if (pk_ready) begin
          cmd.put  = 1'b1;
          cmd.code = clear_code + CW'(1);
          width_d  = width_nx;
          rpend_d  = 1'b0;
          state_d  = S_FIN;
        end
      end
      S_FIN: begin
        if (pk_ready) begin
          cmd.fin     = 1'b1;
          cmd.img_end = last_q;
          if (last_q) begin
            first_d = 1'b1;
          end
          state_d = sweep_q ? S_SWEEP : S_IDLE;
        end
      end
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = scnt_q;
        ram_wdata = '0;
        if (scnt_q == LAST_SLOT) begin
          scnt_d  = '0;
          sweep_d = 1'b0;
          state_d = S_IDLE;
        end else begin
          scnt_d = scnt_q + SLOT_AW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      min_q    <= 4'd8;
      img_q    <= 4'd8;
      prefix_q <= '0;
      nfree_q  <= (CW+1)'(258);
      width_q  <= 4'd9;
      rpend_q  <= 1'b0;
      first_q  <= 1'b1;
      last_q   <= 1'b0;
      sweep_q  <= 1'b0;
      scnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) begin
        min_q <= min_code_size_i;
      end
      img_q    <= img_d;
      prefix_q <= prefix_d;
      nfree_q  <= nfree_d;
      width_q  <= width_d;
      rpend_q  <= rpend_d;
      first_q  <= first_d;
      last_q   <= last_d;
      sweep_q  <= sweep_d;
      scnt_q   <= scnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    key_q  <= key_d;
    idx_q  <= idx_d;
    disp_q <= disp_d;
  end

  assign in_stall_o = (state_q != S_IDLE);

  glcp_dict_ram #(
    .DEPTH(HASH_SLOTS),
    .WIDTH(ENTRY_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  glcp_packer u_packer (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .ready_o          (pk_ready),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .data_byte_o      (data_byte_o),
    .subblock_end_o   (subblock_end_o),
    .subblock_length_o(subblock_length_o),
    .image_done_o     (image_done_o),
    .run_last_o       (run_last_o)
  );

endmodule

// File: rtl/core/glcp_dict_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcp_dict_ram
// Single-port-write, single-port-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module glcp_dict_ram #(
  parameter int unsigned DEPTH = 5003,
  parameter int unsigned WIDTH = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/glcp_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcp_packer
// Packs variable-width codes LSB-first into bytes, one byte per cycle when not
// stalled, and tags sub-block ends, image end and each transaction's last byte.
// ----------------------------------------------------------------------------
module glcp_packer
  import glcp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pk_cmd_t    cmd_i,
  output logic       ready_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       subblock_end_o,
  output logic [7:0] subblock_length_o,
  output logic       image_done_o,
  output logic       run_last_o
);

  logic [18:0] acc_q, acc_d;
  logic [4:0]  bits_q, bits_d;
  logic        fin_q, fin_d;
  logic        fimg_q, fimg_d;
  logic [7:0]  sbcnt_q, sbcnt_d;
  logic        pend_q, pend_d;
  logic [7:0]  pbyte_q, pbyte_d;
  logic [7:0]  pcnt_q, pcnt_d;
  logic        ov_q, ov_d;
  logic [7:0]  obyte_q, obyte_d;
  logic        oend_q, oend_d;
  logic [7:0]  olen_q, olen_d;
  logic        odone_q, odone_d;
  logic        olast_q, olast_d;

  logic        out_free;
  logic        produce;
  logic [11:0] cmask;
  logic [7:0]  cnt_new;
  logic        pend_full;

  assign out_free  = !ov_q || !out_stall_i;
  assign produce   = (bits_q >= 5'd8) && (!pend_q || out_free);
  assign cmask     = 12'((13'd1 << cmd_i.width) - 13'd1);
  assign cnt_new   = sbcnt_q + 8'd1;
  assign pend_full = (pcnt_q == 8'(SUBBLOCK_BYTES));
  assign ready_o   = (bits_q < 5'd8) && !fin_q;

  always_comb begin
    acc_d   = acc_q;
    bits_d  = bits_q;
    fin_d   = fin_q;
    fimg_d  = fimg_q;
    sbcnt_d = sbcnt_q;
    pend_d  = pend_q;
    pbyte_d = pbyte_q;
    pcnt_d  = pcnt_q;
    ov_d    = ov_q && out_stall_i;
    obyte_d = obyte_q;
    oend_d  = oend_q;
    olen_d  = olen_q;
    odone_d = odone_q;
    olast_d = olast_q;

    if (ready_o && cmd_i.put) begin
      acc_d  = acc_q | (19'(cmd_i.code & cmask) << bits_q[2:0]);
      bits_d = bits_q + 5'(cmd_i.width);
    end else if (ready_o && cmd_i.fin) begin
      fin_d  = 1'b1;
      fimg_d = cmd_i.img_end;
      if (cmd_i.img_end && bits_q != 5'd0) begin
        bits_d = 5'd8;
      end
    end else if (produce) begin
      if (pend_q) begin
        ov_d    = 1'b1;
        obyte_d = pbyte_q;
        oend_d  = pend_full;
        olen_d  = pend_full ? pcnt_q : 8'd0;
        odone_d = 1'b0;
        olast_d = 1'b0;
      end
      pend_d  = 1'b1;
      pbyte_d = acc_q[7:0];
      pcnt_d  = cnt_new;
      sbcnt_d = (cnt_new == 8'(SUBBLOCK_BYTES)) ? 8'd0 : cnt_new;
      acc_d   = acc_q >> 8;
      bits_d  = bits_q - 5'd8;
    end else if (fin_q && out_free) begin
      fin_d = 1'b0;
      if (pend_q) begin
        pend_d  = 1'b0;
        ov_d    = 1'b1;
        obyte_d = pbyte_q;
        oend_d  = fimg_q || pend_full;
        olen_d  = (fimg_q || pend_full) ? pcnt_q : 8'd0;
        odone_d = fimg_q;
        olast_d = 1'b1;
      end
      if (fimg_q) begin
        sbcnt_d = 8'd0;
        bits_d  = 5'd0;
        acc_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      bits_q  <= '0;
      fin_q   <= 1'b0;
      fimg_q  <= 1'b0;
      sbcnt_q <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      bits_q  <= bits_d;
      fin_q   <= fin_d;
      fimg_q  <= fimg_d;
      sbcnt_q <= sbcnt_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pbyte_q <= pbyte_d;
    pcnt_q  <= pcnt_d;
    obyte_q <= obyte_d;
    oend_q  <= oend_d;
    olen_q  <= olen_d;
    odone_q <= odone_d;
    olast_q <= olast_d;
  end

  assign out_valid_o       = ov_q;
  assign data_byte_o       = obyte_q;
  assign subblock_end_o    = oend_q;
  assign subblock_length_o = olen_q;
  assign image_done_o      = odone_q;
  assign run_last_o        = olast_q;

endmodule

// File: sim/glcp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcp_checker
// Monitors the pixel, byte and config ports of the GIF LZW code packer.
// Runs its own LZW encoder on every accepted pixel to predict the output
// bytes, then compares each accepted byte field by field in order.
// ----------------------------------------------------------------------------
module glcp_checker
  import glcp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] min_code_size_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] pixel_index_i,
  input  logic       last_pixel_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] data_byte_i,
  input  logic       subblock_end_i,
  input  logic [7:0] subblock_length_i,
  input  logic       image_done_i,
  input  logic       run_last_i,
  output int         errors_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       sb_end;
    logic [7:0] sb_len;
    logic       done;
    logic       run_last;
  } byte_rec_t;

  localparam int unsigned KEY_VALID = 1 << 20;
  localparam int unsigned TOP_CODE  = 1 << MAX_CODE_BITS;
  localparam int          MAX_BYTES = 8;

  logic [20:0] key_tab [HASH_SLOTS];
  logic [11:0] code_tab[HASH_SLOTS];
  int unsigned cfg_size, img_size, prefix, next_free, cw, wlim;
  int unsigned reset_pend, residue, rcount, sb_count;
  bit          new_image;
  byte_rec_t   byte_q[$];
  byte_rec_t   step_q[$];
  int          err_cnt;

  assign errors_o  = err_cnt;
  assign pending_o = byte_q.size();

  function automatic void set_width(int unsigned w);
    cw   = w;
    wlim = (w >= MAX_CODE_BITS) ? TOP_CODE : ((1 << w) - 1);
  endfunction

  function automatic void emit_byte(int unsigned b);
    byte_rec_t r;
    if (step_q.size() >= MAX_BYTES) return;
    sb_count++;
    r.data     = b[7:0];
    r.sb_end   = (sb_count >= SUBBLOCK_BYTES);
    r.sb_len   = r.sb_end ? sb_count[7:0] : 8'd0;
    r.done     = 1'b0;
    r.run_last = 1'b0;
    if (r.sb_end) sb_count = 0;
    step_q.push_back(r);
  endfunction

  function automatic void put_code(int unsigned code);
    int unsigned acc, bits;
    code = code & ((1 << cw) - 1);
    acc  = residue | (code << rcount);
    bits = rcount + cw;
    while (bits >= 8) begin
      emit_byte(acc & 8'hff);
      acc  = acc >> 8;
      bits = bits - 8;
    end
    rcount  = bits;
    residue = acc & ((1 << bits) - 1);
    if (reset_pend != 0) begin
      set_width(img_size + 1);
      reset_pend = 0;
    end else if (next_free > wlim && cw < MAX_CODE_BITS) begin
      set_width(cw + 1);
    end
  endfunction

  function automatic void clear_dict();
    for (int i = 0; i < HASH_SLOTS; i++) key_tab[i] = '0;
  endfunction

  function automatic void encode_pixel(logic [7:0] pix, logic last);
    int unsigned c, clr, key, idx, disp;
    bit found, empty;
    byte_rec_t r;
    step_q.delete();
    found = 0;
    empty = 0;
    if (new_image) begin
      img_size   = (cfg_size < 2) ? 2 : (cfg_size > 8) ? 8 : cfg_size;
      clr        = 1 << img_size;
      clear_dict();
      next_free  = clr + 2;
      set_width(img_size + 1);
      reset_pend = 0;
      residue    = 0;
      rcount     = 0;
      sb_count   = 0;
      c          = pix & ((1 << img_size) - 1);
      put_code(clr);
      prefix     = c;
      new_image  = 0;
    end else begin
      clr = 1 << img_size;
      c   = pix & ((1 << img_size) - 1);
      key = ((c << MAX_CODE_BITS) + prefix) | KEY_VALID;
      idx = ((c << HASH_SHIFT) ^ prefix) % HASH_SLOTS;
      if (key_tab[idx] == key) found = 1;
      else if (!key_tab[idx][20]) empty = 1;
      else begin
        disp = (idx == 0) ? 1 : HASH_SLOTS - idx;
        for (int k = 0; k < HASH_SLOTS; k++) begin
          idx = (idx >= disp) ? idx - disp : idx + HASH_SLOTS - disp;
          if (key_tab[idx] == key) begin
            found = 1;
            break;
          end
          if (!key_tab[idx][20]) begin
            empty = 1;
            break;
          end
        end
      end
      if (found) begin
        prefix = code_tab[idx];
      end else begin
        put_code(prefix);
        prefix = c;
        if (next_free < TOP_CODE) begin
          if (empty) begin
            code_tab[idx] = next_free[11:0];
            key_tab[idx]  = key[20:0];
          end
          next_free++;
        end else begin
          clear_dict();
          next_free  = clr + 2;
          reset_pend = 1;
          put_code(clr);
        end
      end
    end
    if (last) begin
      put_code(prefix);
      put_code(clr + 1);
      if (rcount > 0) begin
        emit_byte(residue);
        residue = 0;
        rcount  = 0;
      end
      if (step_q.size() > 0) begin
        r = step_q[$];
        if (sb_count > 0) begin
          r.sb_end = 1'b1;
          r.sb_len = sb_count[7:0];
          sb_count = 0;
        end
        r.done    = 1'b1;
        step_q[$] = r;
      end
      new_image = 1;
    end
    if (step_q.size() > 0) begin
      r          = step_q[$];
      r.run_last = 1'b1;
      step_q[$]  = r;
    end
    foreach (step_q[i]) byte_q.push_back(step_q[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    byte_rec_t exp_r, got_r;
    if (!rst_ni) begin
      clear_dict();
      cfg_size   = 8;
      img_size   = 8;
      prefix     = 0;
      next_free  = 258;
      set_width(9);
      reset_pend = 0;
      residue    = 0;
      rcount     = 0;
      sb_count   = 0;
      new_image  = 1;
      byte_q.delete();
      err_cnt    = 0;
    end else begin
      if (cfg_we_i) cfg_size = min_code_size_i;
      if (in_valid_i && !in_stall_i) encode_pixel(pixel_index_i, last_pixel_i);
      if (out_valid_i && !out_stall_i) begin
        got_r = '{data_byte_i, subblock_end_i, subblock_length_i, image_done_i, run_last_i};
        if (byte_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected byte transaction, actual %p", $time, got_r);
        end else begin
          exp_r = byte_q.pop_front();
          if (exp_r !== got_r) begin
            err_cnt++;
            $display("%0t: byte mismatch, expected %p, actual %p", $time, exp_r, got_r);
          end
        end
      end
    end
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the GIF LZW code packer.
// Drives directed and random images across code sizes and idle/stall mixes;
// the checker predicts and compares the byte stream.
// ----------------------------------------------------------------------------
module tb_top;
  import glcp_pkg::*;

  localparam int WD_LIMIT = 40000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [3:0] min_code_size_i = 4'd8;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] pixel_index_i = 8'd0;
  logic       last_pixel_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] data_byte_o;
  logic       subblock_end_o;
  logic [7:0] subblock_length_o;
  logic       image_done_o;
  logic       run_last_o;
  int         errors, pending;
  int         idle_pct = 0, stall_pct = 0;
  int         wd_cnt = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  gif_lzw_code_packer uut (.*);

  glcp_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .min_code_size_i,
    .in_valid_i, .in_stall_i(in_stall_o), .pixel_index_i, .last_pixel_i,
    .out_valid_i(out_valid_o), .out_stall_i, .data_byte_i(data_byte_o),
    .subblock_end_i(subblock_end_o), .subblock_length_i(subblock_length_o),
    .image_done_i(image_done_o), .run_last_i(run_last_o),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      wd_cnt <= 0;
    end else if (rst_ni) begin
      wd_cnt <= wd_cnt + 1;
      if (wd_cnt >= WD_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_pixel(input logic [7:0] pix, input logic last);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_index_i <= pix;
    last_pixel_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // sweep after a first pixel may still be running when the queue empties
  task automatic write_size(input logic [3:0] v);
    drain();
    repeat (5100) @(posedge clk_i);
    cfg_we_i        <= 1'b1;
    min_code_size_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_image(input int n, input bit wide);
    logic [7:0] p;
    for (int i = 0; i < n; i++) begin
      if (wide || $urandom_range(1)) p = 8'($urandom_range(255));
      else p = 8'($urandom_range(3));
      send_pixel(p, i == n - 1);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel(8'hff, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hff, 1'b1);
    write_size(4'd2);
    send_pixel(8'hff, 1'b0);
    send_pixel(8'hfc, 1'b0);
    send_pixel(8'h03, 1'b0);
    send_pixel(8'hff, 1'b0);
    send_pixel(8'hff, 1'b1);
    write_size(4'd0);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'h02, 1'b0);
    send_pixel(8'h03, 1'b1);
    write_size(4'd15);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h7f, 1'b1);
    send_pixel(8'h05, 1'b0);
    write_size(4'd3);
    send_pixel(8'h05, 1'b0);
    send_pixel(8'h05, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 37 : 74) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 37 : 74) : 0;
      write_size((ph == 0) ? 4'd2 : (ph == 1) ? 4'd8 : 4'($urandom_range(2, 8)));
      for (int im = 0; im < 4; im++) begin
        send_image($urandom_range(1, 11), 1'($urandom_range(1)));
        if (ph == 1 && im == 1) begin
          send_pixel(8'($urandom_range(255)), 1'b0);
          drain();
          send_pixel(8'($urandom_range(255)), 1'b1);
        end
      end
    end

    idle_pct  = 0;
    stall_pct = 0;

    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
